// ===== rtl/crcf_pkg.sv =====
// Package for the CRC codeword framer: register indexes, sizes, the stage
// record and the bit-serial remainder function. No dependencies.
`default_nettype none

package crcf_pkg;

   localparam int MaxGenBits = 17;
   localparam int MaxDeg     = MaxGenBits - 1;
   localparam int DivBits    = 8 + MaxDeg;
   localparam int CwBits     = 2 * (4 + MaxDeg);
   localparam int CwCntBits  = $clog2(CwBits + 1);
   localparam int LenBits    = 5;

   typedef enum logic [1:0] {
      CSR_POLY = 2'd0,
      CSR_GLEN = 2'd1,
      CSR_MODE = 2'd2,
      CSR_MLEN = 2'd3
   } csr_idx_type;

   // one item after remainder computation, before packing
   typedef struct packed {
      logic [CwBits-1:0]    cw_bits;
      logic [CwCntBits-1:0] cw_cnt;
      logic                 first;
      logic                 last;
      logic [3:0]           pad;
   } stage_type;

   // Divide data * x^MaxDeg by a generator that has been shifted up so that
   // its leading term sits at bit MaxDeg. Return the remainder still aligned
   // at the top of the low MaxDeg bits; the caller shifts it down by
   // MaxDeg - degree. Datawords shorter than 8 bits just leave the first
   // steps idle because their top bits are zero.
   function automatic logic [MaxDeg-1:0] crc_rem(input logic [7:0] data,
                                                  input logic [MaxGenBits-1:0] gen_al);
      logic [DivBits-1:0] dvd;
      dvd = {data, {MaxDeg{1'b0}}};
      for (int i = 0; i < 8; i++) begin
         if (dvd[DivBits-1-i]) begin
            dvd = dvd ^ (DivBits'(gen_al) << (7 - i));
         end
      end
      return dvd[MaxDeg-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/crc_codeword_framer_unit.sv =====
// CRC codeword framer top level: input register, remainder stage and the
// byte packing buffer. Depends on crcf_pkg.
`default_nettype none

// Systematic CRC encoder with configurable generator and byte framing.
//
// req_* carries message bytes. Each byte becomes one 8-bit dataword or two
// 4-bit datawords (high nibble first); each dataword is followed by its
// remainder modulo the generator. Codeword bits are packed MSB first into
// rsp_* items. The first item of a message is a header byte holding the
// pad count P, followed by P zero bits ahead of the codeword stream.
// rsp_tlast marks the last byte of a message.
//
// Pipeline: input register, remainder register, then a 64-bit packing
// buffer that shifts out one byte per cycle while rsp_tready is high. The
// first byte of an item shows on rsp_* once the item has passed the input
// and remainder registers and been loaded into the buffer. An input byte
// yields 1 to 7 output bytes, up to 6 for codeword bytes plus the header on
// the first byte of a message, so the sustained rate of items is set by the
// drain of the packing buffer. Upstream stages keep accepting while the
// buffer drains, and a stalled rsp_tready holds the buffer and backs the
// stages up in turn.
//
// Reset clears all stages, the message byte count and the pending bits and
// loads the register defaults. Configure through csr_* only while idle.

module crc_codeword_framer_unit
   import crcf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [MaxGenBits-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] data_byte
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [7:0]            rsp_tdata,   // [7:0] out_byte
   output      logic                  rsp_tlast
);

   // configuration registers
   logic [MaxGenBits-1:0] poly_ff;
   logic [LenBits-1:0]    glen_ff;
   logic                  mode_ff;
   logic [15:0]           mlen_ff;

   // input register
   logic       s0_valid_ff;
   logic [7:0] s0_data_ff;

   // remainder stage
   logic       s1_valid_ff;
   stage_type  s1_ff;
   stage_type  s1_in;
   logic [15:0] bt_ff;
   logic [15:0] bt_in;

   // packing buffer and carried bits
   logic [63:0] obuf_ff, obuf_in;
   logic [2:0]  obytes_ff, obytes_in;
   logic        olast_ff, olast_in;
   logic [6:0]  pend_ff, pend_in;
   logic [2:0]  pcnt_ff, pcnt_in;

   // handshake
   logic rsp_fire;
   logic load2;
   logic move01;

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign load2      = s1_valid_ff && ((obytes_ff == 3'd0) ||
                                       ((obytes_ff == 3'd1) && rsp_tready));
   assign move01     = s0_valid_ff && (!s1_valid_ff || load2);
   assign req_tready = !s0_valid_ff || move01;

   assign rsp_tvalid = (obytes_ff != 3'd0);
   assign rsp_tdata  = obuf_ff[63:56];
   assign rsp_tlast  = olast_ff && (obytes_ff == 3'd1);

   // ---------------------------------------------------------------------
   // Remainder stage: clamp the generator, divide, form the codeword bits,
   // and decide header and message end from the byte count.
   // ---------------------------------------------------------------------
   logic [LenBits-1:0]    len;
   logic [LenBits-1:0]    deg;
   logic [LenBits-1:0]    up;
   logic [MaxGenBits:0]   len_mask;
   logic [MaxGenBits-1:0] gen_al;
   logic [MaxDeg-1:0]     rem_hi, rem_lo, rem_by;
   logic [MaxDeg-1:0]     crc_hi, crc_lo, crc_by;
   logic [19:0]           cw_hi, cw_lo;
   logic [5:0]            n_nib;
   logic [16:0]           bt_next;
   logic [16:0]           mb;
   logic [2:0]            per3;
   logic [2:0]            rem3;

   always_comb begin
      if (glen_ff < LenBits'(2)) begin
         len = LenBits'(2);
      end else if (glen_ff > LenBits'(MaxGenBits)) begin
         len = LenBits'(MaxGenBits);
      end else begin
         len = glen_ff;
      end
      deg      = len - LenBits'(1);
      up       = LenBits'(MaxDeg) - deg;
      len_mask = ((MaxGenBits+1)'(1) << len) - (MaxGenBits+1)'(1);
      gen_al   = MaxGenBits'((poly_ff & len_mask[MaxGenBits-1:0]) << up);

      crc_by = crc_rem(s0_data_ff, gen_al);
      crc_hi = crc_rem({4'd0, s0_data_ff[7:4]}, gen_al);
      crc_lo = crc_rem({4'd0, s0_data_ff[3:0]}, gen_al);
      rem_by = crc_by >> up;
      rem_hi = crc_hi >> up;
      rem_lo = crc_lo >> up;

      cw_hi = (20'(s0_data_ff[7:4]) << deg) | 20'(rem_hi);
      cw_lo = (20'(s0_data_ff[3:0]) << deg) | 20'(rem_lo);
      n_nib = 6'd4 + 6'(deg);

      if (mode_ff) begin
         s1_in.cw_bits = (CwBits'(s0_data_ff) << deg) | CwBits'(rem_by);
         s1_in.cw_cnt  = CwCntBits'(8) + CwCntBits'(deg);
         per3          = deg[2:0];
      end else begin
         s1_in.cw_bits = (CwBits'(cw_hi) << n_nib) | CwBits'(cw_lo);
         s1_in.cw_cnt  = CwCntBits'(8) + CwCntBits'({deg, 1'b0});
         per3          = {deg[1:0], 1'b0};
      end

      // pad count: 8 minus (message bytes * bits per byte) mod 8
      rem3      = 3'(mlen_ff[2:0] * per3);
      s1_in.pad = 4'd8 - 4'(rem3);

      mb          = (mlen_ff == 16'd0) ? 17'h10000 : 17'(mlen_ff);
      bt_next     = 17'(bt_ff) + 17'd1;
      s1_in.first = (bt_ff == 16'd0);
      s1_in.last  = (bt_next >= mb);
      bt_in       = s1_in.last ? 16'd0 : bt_next[15:0];
   end

   // ---------------------------------------------------------------------
   // Packing: prefix (header plus pad zeros, or carried bits), then the
   // codeword bits; left-align into the buffer and keep the odd tail.
   // ---------------------------------------------------------------------
   logic [15:0] pre_val;
   logic [4:0]  pre_cnt;
   logic [5:0]  total;
   logic [63:0] acc;
   logic [6:0]  lsh;
   logic [6:0]  total_up;

   always_comb begin
      if (s1_ff.first) begin
         pre_val = 16'(s1_ff.pad) << s1_ff.pad;
         pre_cnt = 5'd8 + 5'(s1_ff.pad);
      end else begin
         pre_val = 16'(pend_ff);
         pre_cnt = 5'(pcnt_ff);
      end
      total    = 6'(pre_cnt) + 6'(s1_ff.cw_cnt);
      acc      = (64'(pre_val) << s1_ff.cw_cnt) | 64'(s1_ff.cw_bits);
      lsh      = 7'd64 - 7'(total);
      total_up = 7'(total) + 7'd7;

      obuf_in   = obuf_ff;
      obytes_in = obytes_ff;
      olast_in  = olast_ff;
      pend_in   = pend_ff;
      pcnt_in   = pcnt_ff;

      if (load2) begin
         obuf_in  = acc << lsh;
         olast_in = s1_ff.last;
         if (s1_ff.last) begin
            // flush the tail as a zero-filled byte, drop carried bits
            obytes_in = total_up[5:3];
            pend_in   = 7'd0;
            pcnt_in   = 3'd0;
         end else begin
            obytes_in = total[5:3];
            pend_in   = acc[6:0] & (7'h7F >> (3'd7 - total[2:0]));
            pcnt_in   = total[2:0];
         end
      end else if (rsp_fire) begin
         obuf_in   = {obuf_ff[55:0], 8'd0};
         obytes_in = obytes_ff - 3'd1;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff     <= MaxGenBits'(11);
         glen_ff     <= LenBits'(4);
         mode_ff     <= 1'b1;
         mlen_ff     <= 16'd1;
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         bt_ff       <= 16'd0;
         obytes_ff   <= 3'd0;
         olast_ff    <= 1'b0;
         pend_ff     <= 7'd0;
         pcnt_ff     <= 3'd0;
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_POLY: poly_ff <= csr_wdata;
               CSR_GLEN: glen_ff <= csr_wdata[LenBits-1:0];
               CSR_MODE: mode_ff <= csr_wdata[0];
               CSR_MLEN: mlen_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end

         if (req_tready) begin
            s0_valid_ff <= req_tvalid;
         end
         if (move01) begin
            s1_valid_ff <= 1'b1;
            bt_ff       <= bt_in;
         end else if (load2) begin
            s1_valid_ff <= 1'b0;
         end

         obytes_ff <= obytes_in;
         olast_ff  <= olast_in;
         pend_ff   <= pend_in;
         pcnt_ff   <= pcnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s0_data_ff <= req_tdata;
      end
      if (move01) begin
         s1_ff <= s1_in;
      end
      obuf_ff <= obuf_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // every item yields at least one byte
   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      load2 |=> (obytes_ff != 3'd0))
      else $error("packing buffer empty after load");

   // draining counts down by one per taken byte
   a_drain_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && (obytes_ff > 3'd1)) |=> (obytes_ff == $past(obytes_ff) - 3'd1))
      else $error("packing buffer count skipped");

   // no bits carried across the end of a message
   a_no_carry_at_end: assert property (@(posedge clock) disable iff (reset)
      (olast_ff && (obytes_ff != 3'd0)) |-> (pcnt_ff == 3'd0))
      else $error("bits pending at message end");

   // a new message starts with no carried bits
   a_first_clean: assert property (@(posedge clock) disable iff (reset)
      (load2 && s1_ff.first) |-> (pcnt_ff == 3'd0))
      else $error("bits pending at message start");

   // a buffer that is stalled keeps its byte
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled byte changed");

endmodule

`default_nettype wire

// ===== tb/crc_codeword_framer_unit_tb.sv =====
// Self-checking testbench for crc_codeword_framer_unit: a scoreboard class that
// predicts the framed codeword bytes, plus stream drivers with random idling.
// Depends on crcf_pkg and the framer RTL only.

import crcf_pkg::*;

class codeword_scoreboard;

   typedef struct packed {
      logic       last;
      logic [7:0] data;
   } framed_byte_type;

   // predicted output bytes, oldest first
   framed_byte_type exp_bytes[$];

   // register copies
   logic [MaxGenBits-1:0] gen_poly;
   logic [4:0]            gen_len;
   logic                  word_mode;
   logic [15:0]           msg_len;

   // packing state
   logic [63:0] bit_buf;
   int unsigned bit_cnt;
   int unsigned taken;

   int errors;
   int checked;
   int messages;

   function new();
      gen_poly  = 17'd11;
      gen_len   = 5'd4;
      word_mode = 1'b1;
      msg_len   = 16'd1;
      bit_buf   = '0;
      bit_cnt   = 0;
      taken     = 0;
      errors    = 0;
      checked   = 0;
      messages  = 0;
   endfunction

   function logic [63:0] low_bits(int unsigned n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
   endfunction

   // append one predicted byte at the young end of the store
   function void queue_byte(framed_byte_type fb);
      exp_bytes = {exp_bytes, fb};
   endfunction

   function void set_reg(csr_idx_type idx, logic [MaxGenBits-1:0] v);
      case (idx)
         CSR_POLY: gen_poly  = v;
         CSR_GLEN: gen_len   = v[4:0];
         CSR_MODE: word_mode = v[0];
         CSR_MLEN: msg_len   = v[15:0];
         default: ;
      endcase
   endfunction

   // move every whole byte at the top of the buffer into the expected store
   function void flush_full_bytes();
      framed_byte_type fb;
      while (bit_cnt >= 8) begin
         fb.data = 8'(bit_buf >> (bit_cnt - 8));
         fb.last = 1'b0;
         bit_cnt -= 8;
         bit_buf &= low_bits(bit_cnt);
         queue_byte(fb);
      end
   endfunction

   // divide one dataword, append dataword and remainder to the buffer
   function void append_codeword(logic [7:0] d, int unsigned dw, int unsigned len);
      logic [63:0] poly;
      logic [63:0] dvd;
      logic [63:0] cw;
      int unsigned deg;
      int unsigned total;
      int unsigned i;
      deg   = len - 1;
      total = dw + deg;
      poly  = 64'(gen_poly) & low_bits(len);
      dvd   = (64'(d) & low_bits(dw)) << deg;
      for (i = 0; i < dw; i++) begin
         if (dvd[total-1-i]) dvd ^= poly << (dw - 1 - i);
      end
      cw      = ((64'(d) & low_bits(dw)) << deg) | (dvd & low_bits(deg));
      bit_buf = ((bit_buf << total) | cw) & low_bits(bit_cnt + total);
      bit_cnt += total;
      flush_full_bytes();
   endfunction

   // note one accepted message byte and predict the bytes it yields
   function void take_byte(logic [7:0] d);
      int unsigned len;
      int unsigned deg;
      int unsigned mb;
      int unsigned per;
      int unsigned pad;
      framed_byte_type fb;
      len = gen_len;
      if (len < 2) len = 2;
      if (len > MaxGenBits) len = MaxGenBits;
      deg = len - 1;
      mb  = (msg_len == 16'd0) ? 65536 : msg_len;
      if (taken == 0) begin
         per     = word_mode ? (8 + deg) : (2 * (4 + deg));
         pad     = 8 - (((mb % 8) * (per % 8)) % 8);
         fb.data = 8'(pad);
         fb.last = 1'b0;
         queue_byte(fb);
         bit_buf = '0;
         bit_cnt = pad;
         flush_full_bytes();
      end
      if (word_mode) begin
         append_codeword(d, 8, len);
      end else begin
         append_codeword({4'h0, d[7:4]}, 4, len);
         append_codeword({4'h0, d[3:0]}, 4, len);
      end
      taken++;
      if (taken >= mb) begin
         if (bit_cnt > 0) begin
            fb.data = 8'(bit_buf << (8 - bit_cnt));
            fb.last = 1'b0;
            queue_byte(fb);
         end
         fb      = exp_bytes[exp_bytes.size() - 1];
         fb.last = 1'b1;
         exp_bytes[exp_bytes.size() - 1] = fb;
         bit_buf = '0;
         bit_cnt = 0;
         taken   = 0;
      end
   endfunction

   task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   task check_out(logic [7:0] d, logic last);
      framed_byte_type fb;
      checked++;
      if (last === 1'b1) messages++;
      if (exp_bytes.size() == 0) begin
         report_mismatch($sformatf("byte %0d: unexpected out_byte %02h tlast %b",
                                   checked, d, last));
      end else begin
         fb = exp_bytes.pop_front();
         if (d !== fb.data)
            report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
                                      checked, d, fb.data));
         if (last !== fb.last)
            report_mismatch($sformatf("byte %0d: end_of_message %b, want %b",
                                      checked, last, fb.last));
      end
   endtask

endclass

module crc_codeword_framer_unit_tb;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [1:0]            csr_index;
   logic [MaxGenBits-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] data_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // [7:0] out_byte
   logic                  rsp_tlast;

   codeword_scoreboard sb = new();

   int   items_sent = 0;
   int   configs    = 0;
   logic gap_free   = 1'b0;   // sender offers back to back while set
   logic long_stall_go = 1'b0; // ask the receiver for one long hold-off

   crc_codeword_framer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 4-unit clock period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Gap length in cycles: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (gap_free) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one item starting at a falling edge; hold it until accepted,
   // then idle for a random gap. Returns at a falling edge.
   task send_byte(input logic [7:0] d);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.take_byte(d);
      items_sent++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Write one register, then keep the register port quiet before returning.
   task write_reg(input csr_idx_type idx, input logic [MaxGenBits-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, v);
      @(negedge clock);
   endtask

   task program_regs(input logic [16:0] poly, input logic [4:0] glen,
                     input logic mode, input logic [15:0] mlen);
      write_reg(CSR_POLY, poly);
      write_reg(CSR_GLEN, 17'(glen));
      write_reg(CSR_MODE, 17'(mode));
      write_reg(CSR_MLEN, 17'(mlen));
      configs++;
   endtask

   // Drop valid, wait until every predicted byte has come out, then let
   // the pipeline idle before anything is reconfigured.
   task settle_outputs();
      req_tvalid <= 1'b0;
      while (sb.exp_bytes.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Receiver: alternate ready runs and stalls of random length; on request,
   // hold off once for a long stretch so the block backs up into its input.
   initial begin
      int   run;
      int   long_left;
      int   r;
      logic ready_state;
      logic stall_seen;
      rsp_tready  = 1'b0;
      run         = 0;
      long_left   = 0;
      ready_state = 1'b0;
      stall_seen  = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_go && !stall_seen) begin
            stall_seen = 1'b1;
            long_left  = 400;
         end
         if (long_left > 0) begin
            long_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (run == 0) begin
               r = $urandom_range(0, 99);
               if (r < 45) begin
                  ready_state = 1'b1;
                  run = $urandom_range(1, 30);
               end else begin
                  ready_state = 1'b0;
                  if (r < 80)      run = $urandom_range(1, 3);
                  else if (r < 95) run = $urandom_range(4, 12);
                  else             run = $urandom_range(30, 60);
               end
            end
            run--;
            rsp_tready <= ready_state;
         end
      end
   end

   // Check every accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         sb.check_out(rsp_tdata, rsp_tlast);
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int          phase;
      int          n;
      int          msgs;
      int          r;
      int unsigned eff;
      logic [16:0] poly;
      logic [4:0]  glen;
      logic        mode;
      logic [15:0] mlen;
      logic [7:0]  d;

      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      csr_we     = 1'b0;
      csr_index  = CSR_POLY;
      csr_wdata  = '0;

      // hold reset, then release it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(negedge clock);

      // ---------------- directed part ----------------
      // reset defaults: one-byte messages, degree 3, whole-byte datawords
      send_byte(8'h00);
      send_byte(8'hFF);
      settle_outputs();

      // widest generator with nibble datawords: header, zero byte, five bytes
      program_regs(17'h1FFFF, 5'd17, 1'b0, 16'd3);
      send_byte(8'hA5);
      send_byte(8'h0F);
      send_byte(8'hF0);
      settle_outputs();

      // leading generator bit clear
      program_regs(17'h00005, 5'd4, 1'b1, 16'd2);
      send_byte(8'h80);
      send_byte(8'h01);
      settle_outputs();

      // length below the minimum acts as the minimum
      program_regs(17'h00003, 5'd0, 1'b0, 16'd4);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h56);
      send_byte(8'h78);
      settle_outputs();

      // length above the maximum, zero message length: leave the message open
      program_regs(17'h10001, 5'd31, 1'b1, 16'd0);
      send_byte(8'hC3);
      send_byte(8'h3C);
      send_byte(8'h99);
      settle_outputs();

      // change everything mid-message and lower the length below the count
      // taken: the next byte closes the message and flushes leftover bits
      program_regs(17'h00001, 5'd1, 1'b0, 16'd2);
      send_byte(8'h55);
      settle_outputs();

      // longest message length, then close it by lowering the length
      program_regs(17'h000AB, 5'd9, 1'b1, 16'd65535);
      send_byte(8'hAA);
      send_byte(8'h01);
      settle_outputs();
      program_regs(17'h000AB, 5'd9, 1'b1, 16'd1);
      send_byte(8'h7E);
      settle_outputs();

      // ---------------- random part ----------------
      phase = 0;
      while (items_sent < 460) begin
         r = $urandom_range(0, 99);
         glen = (r < 12) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(2, 17));
         eff = glen;
         if (eff < 2) eff = 2;
         if (eff > MaxGenBits) eff = MaxGenBits;
         poly = 17'($urandom_range(1, 131071));
         if ($urandom_range(0, 3) != 0) poly = poly | (17'd1 << (eff - 1));
         mode = 1'($urandom_range(0, 1));
         r = $urandom_range(0, 99);
         if (r < 70)      mlen = 16'($urandom_range(1, 6));
         else if (r < 94) mlen = 16'($urandom_range(7, 24));
         else if (r < 97) mlen = 16'd0;
         else             mlen = 16'd65535;
         program_regs(poly, glen, mode, mlen);

         // mostly whole messages; now and then stop partway through one
         if (mlen == 16'd0 || mlen > 16'd24) begin
            n = $urandom_range(5, 15);
         end else begin
            msgs = $urandom_range(1, 4);
            n = mlen * msgs;
            if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
         end

         if (phase == 2) begin
            // back up the whole pipeline behind a long receiver stall
            if (n < 40) n = 40;
            gap_free      <= 1'b1;
            long_stall_go <= 1'b1;
         end else begin
            gap_free <= ($urandom_range(0, 3) == 0);
         end

         repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 5)       d = 8'h00;
            else if (r < 10) d = 8'hFF;
            else             d = 8'($urandom_range(0, 255));
            send_byte(d);
         end
         settle_outputs();
         phase++;
      end

      // let any stray output show up before the verdict
      repeat (12) @(negedge clock);

      $display("tb: %0d message bytes sent over %0d register settings",
               items_sent, configs);
      $display("tb: %0d output bytes compared, %0d messages closed",
               sb.checked, sb.messages);
      if (sb.errors == 0 && sb.exp_bytes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
